// ----- rtl/core/spd_pkg.sv -----
// Package for the slotted page directory: sizes, operation codes and the
// structs passed between the control and the free-slot search chain.
// No dependencies.
package spd_pkg;

    localparam int MAX_SLOTS    = 512;
    localparam int HEADER_BYTES = 8;
    localparam int SLOT_BYTES   = 4;
    localparam int PAGE_RESET   = 4096;

    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int BYTE_W    = 16;
    localparam int N_CELLS   = 8;
    localparam int CELL_W    = $clog2(N_CELLS);
    localparam int CELL_BITS = MAX_SLOTS / N_CELLS;
    localparam int LOC_W     = $clog2(CELL_BITS);

    typedef enum logic [2:0] {
        FUNC_INIT   = 3'd0,
        FUNC_INSERT = 3'd1,
        FUNC_DELETE = 3'd2,
        FUNC_GET    = 3'd3,
        FUNC_UPDATE = 3'd4
    } t_func;

    // search token travelling down the cell chain
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_scan;

    // free-map bit update broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic              free;
    } t_bm_wr;

    typedef struct packed {
        logic [BYTE_W-1:0] offset;
        logic [BYTE_W-1:0] length;
    } t_entry;

endpackage

// ----- rtl/core/spd_if.sv -----
// Channel interfaces of the slotted page directory: operation items,
// result items and the page size write port. Depends on spd_pkg.
interface spd_item_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                func;
    logic [spd_pkg::SLOT_W-1:0] slot_id;
    logic [spd_pkg::BYTE_W-1:0] rec_len;

    modport source (output valid, func, slot_id, rec_len, input ready);
    modport sink   (input valid, func, slot_id, rec_len, output ready);
endinterface

interface spd_result_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [spd_pkg::SLOT_W-1:0] slot_index;
    logic [spd_pkg::BYTE_W-1:0] record_offset;
    logic [spd_pkg::BYTE_W-1:0] record_length;
    logic [spd_pkg::BYTE_W-1:0] free_bytes;
    logic [spd_pkg::CNT_W-1:0]  slot_count;

    modport source (output valid, ok, slot_index, record_offset, record_length,
                    free_bytes, slot_count, input ready);
    modport sink   (input valid, ok, slot_index, record_offset, record_length,
                    free_bytes, slot_count, output ready);
endinterface

interface spd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [spd_pkg::BYTE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/slotted_page_directory.sv -----
// Slotted page directory: slot (offset, length) table, free gap tracking and
// a free-slot search chain of spd_cell. Depends on spd_pkg, spd_if, spd_cell.
//
// One item at a time. Delete, get and update pass the states accept, table
// read, check and result before the next item can be accepted; init and
// unknown codes pass accept, read and result. Insert passes accept and
// read, then the search token walks the chain one cell per cycle to find
// the lowest free slot, and then the result is loaded. The result is valid
// from the cycle in which the next item can be accepted, so a new item is
// accepted while the previous result still waits to be taken; a finished
// item waits until the result register is free. The page size register can
// be written at any time and applies at the next init; no clearing pass is
// needed after reset.
module slotted_page_directory (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spd_item_if.sink      i_item,
    spd_result_if.source  o_result,
    spd_cfg_if.sink       i_cfg
);
    import spd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [2:0]         r_func;
    logic [SLOT_W-1:0]  r_id;
    logic [BYTE_W-1:0]  r_len;
    logic [BYTE_W-1:0]  r_page_bytes;
    logic [CNT_W-1:0]   r_dir;
    logic [BYTE_W-1:0]  r_gap_begin;
    logic [BYTE_W-1:0]  r_gap_end;

    logic               r_res_ok;
    logic [SLOT_W-1:0]  r_res_idx;
    logic [BYTE_W-1:0]  r_res_offs;
    logic [BYTE_W-1:0]  r_res_len;

    logic               r_out_valid;
    logic               r_out_ok;
    logic [SLOT_W-1:0]  r_out_idx;
    logic [BYTE_W-1:0]  r_out_offs;
    logic [BYTE_W-1:0]  r_out_len;
    logic [BYTE_W-1:0]  r_out_free;
    logic [CNT_W-1:0]   r_out_count;

    t_entry             r_mem [MAX_SLOTS];
    t_entry             r_mem_q;

    logic               w_accept;
    logic               w_out_free;
    logic [BYTE_W-1:0]  w_gap;
    logic               w_live;
    logic               w_found;
    logic [SLOT_W-1:0]  w_target;
    logic [BYTE_W:0]    w_need;
    logic               w_fits;
    logic [BYTE_W-1:0]  w_new_end;
    logic               w_clear;
    logic               w_mem_we;
    logic [SLOT_W-1:0]  w_mem_wa;
    t_entry             w_mem_wd;
    t_bm_wr             w_bm_wr;
    t_scan              w_link [N_CELLS+1];

    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;
    assign w_out_free   = !r_out_valid || o_result.ready;

    assign w_gap  = (r_gap_end > r_gap_begin) ? (r_gap_end - r_gap_begin) : '0;
    assign w_live = ({1'b0, r_id} < r_dir) && (r_mem_q.length != '0);

    // insert decision, valid when the token leaves the last cell
    assign w_found   = w_link[N_CELLS].found;
    assign w_target  = w_found ? w_link[N_CELLS].idx : r_dir[SLOT_W-1:0];
    assign w_need    = {1'b0, r_len} + (w_found ? (BYTE_W+1)'(0) : (BYTE_W+1)'(SLOT_BYTES));
    assign w_fits    = ({1'b0, w_gap} >= w_need) && (w_found || (r_dir < CNT_W'(MAX_SLOTS)));
    assign w_new_end = r_gap_end - r_len;

    assign w_clear = (r_state == S_READ) && (r_func == FUNC_INIT);

    always_comb begin
        w_mem_we     = 1'b0;
        w_mem_wa     = r_id;
        w_mem_wd     = '0;
        w_bm_wr      = '0;
        w_bm_wr.idx  = r_id;
        unique case (r_state)
            S_CHECK: begin
                if (r_func == FUNC_DELETE && w_live) begin
                    w_mem_we     = 1'b1;
                    w_bm_wr.en   = 1'b1;
                    w_bm_wr.free = 1'b1;
                end else if (r_func == FUNC_UPDATE && w_live && r_len <= r_mem_q.length) begin
                    w_mem_we        = 1'b1;
                    w_mem_wd.offset = r_mem_q.offset;
                    w_mem_wd.length = r_len;
                    w_bm_wr.en      = 1'b1;
                    w_bm_wr.free    = (r_len == '0);
                end
            end
            S_SCAN: begin
                if (w_link[N_CELLS].valid && w_fits) begin
                    w_mem_we        = 1'b1;
                    w_mem_wa        = w_target;
                    w_mem_wd.offset = w_new_end;
                    w_mem_wd.length = r_len;
                    w_bm_wr.en      = 1'b1;
                    w_bm_wr.idx     = w_target;
                    w_bm_wr.free    = (r_len == '0);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        r_mem_q <= r_mem[r_id];
    end

    assign w_link[0].valid = (r_state == S_READ) && (r_func == FUNC_INSERT);
    assign w_link[0].found = 1'b0;
    assign w_link[0].idx   = '0;

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        spd_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (CELL_W'(k)),
            .i_clear   (w_clear),
            .i_bm_wr   (w_bm_wr),
            .i_scan    (w_link[k]),
            .o_scan    (w_link[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= BYTE_W'(PAGE_RESET);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_page_bytes <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dir       <= '0;
            r_gap_begin <= BYTE_W'(HEADER_BYTES);
            r_gap_end   <= BYTE_W'(PAGE_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func  <= i_item.func;
                        r_id    <= i_item.slot_id;
                        r_len   <= i_item.rec_len;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_res_ok   <= (r_func == FUNC_INIT);
                    r_res_idx  <= r_id;
                    r_res_offs <= '0;
                    r_res_len  <= '0;
                    unique case (r_func)
                        FUNC_INIT: begin
                            r_dir       <= '0;
                            r_gap_begin <= BYTE_W'(HEADER_BYTES);
                            r_gap_end   <= r_page_bytes;
                            r_state     <= S_DONE;
                        end
                        FUNC_INSERT: r_state <= S_SCAN;
                        FUNC_DELETE, FUNC_GET, FUNC_UPDATE: r_state <= S_CHECK;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_CHECK: begin
                    if (r_func == FUNC_DELETE && w_live) begin
                        r_res_ok <= 1'b1;
                    end else if (r_func == FUNC_GET && w_live) begin
                        r_res_ok   <= 1'b1;
                        r_res_offs <= r_mem_q.offset;
                        r_res_len  <= r_mem_q.length;
                    end else if (r_func == FUNC_UPDATE && w_live && r_len <= r_mem_q.length) begin
                        r_res_ok   <= 1'b1;
                        r_res_offs <= r_mem_q.offset;
                        r_res_len  <= r_len;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (w_link[N_CELLS].valid) begin
                        if (w_fits) begin
                            r_gap_end  <= w_new_end;
                            r_res_ok   <= 1'b1;
                            r_res_idx  <= w_target;
                            r_res_offs <= w_new_end;
                            r_res_len  <= r_len;
                            if (!w_found) begin
                                r_dir       <= r_dir + CNT_W'(1);
                                r_gap_begin <= r_gap_begin + BYTE_W'(SLOT_BYTES);
                            end
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_ok    <= r_res_ok;
                        r_out_idx   <= r_res_idx;
                        r_out_offs  <= r_res_offs;
                        r_out_len   <= r_res_len;
                        r_out_free  <= w_gap;
                        r_out_count <= r_dir;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.ok            = r_out_ok;
    assign o_result.slot_index    = r_out_idx;
    assign o_result.record_offset = r_out_offs;
    assign o_result.record_length = r_out_len;
    assign o_result.free_bytes    = r_out_free;
    assign o_result.slot_count    = r_out_count;

endmodule

// ----- rtl/core/spd_cell.sv -----
// One cell of the free-slot search chain: holds a slice of the free map
// and passes the lowest-free-slot token to its neighbor. Depends on spd_pkg.
module spd_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [spd_pkg::CELL_W-1:0]  i_cell_id,
    input  logic                        i_clear,
    input  spd_pkg::t_bm_wr             i_bm_wr,
    input  spd_pkg::t_scan              i_scan,
    output spd_pkg::t_scan              o_scan
);
    import spd_pkg::*;

    logic [CELL_BITS-1:0] r_bits;
    t_scan                r_scan;
    logic                 w_any;
    logic [LOC_W-1:0]     w_loc;
    logic                 w_hit;

    assign w_any = |r_bits;
    assign w_hit = i_bm_wr.en && (i_bm_wr.idx[SLOT_W-1 -: CELL_W] == i_cell_id);

    always_comb begin
        w_loc = '0;
        for (int j = CELL_BITS - 1; j >= 0; j--) begin
            if (r_bits[j]) begin
                w_loc = LOC_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bits <= '0;
        end else if (w_hit) begin
            r_bits[i_bm_wr.idx[LOC_W-1:0]] <= i_bm_wr.free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.valid <= 1'b0;
        end else begin
            r_scan.valid <= i_scan.valid;
        end
        r_scan.found <= i_scan.found | w_any;
        r_scan.idx   <= i_scan.found ? i_scan.idx : {i_cell_id, w_loc};
    end

    assign o_scan = r_scan;

endmodule
